// ===== rtl/gpr_pkg.sv =====
// shared types, constants and layout lookup for the gamepad report decoder
package gpr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned NUM_CAP = 7;
    localparam int unsigned SLOT_W  = 3;

    localparam logic [BYTE_W-1:0] PREFIX_BYTE = 8'hA1;
    localparam logic [BYTE_W-1:0] ID_FULL     = 8'h31;
    localparam logic [BYTE_W-1:0] ID_MINIMAL  = 8'h01;

    localparam logic [POS_W-1:0] POS_PREFIX   = 4'd0;
    localparam logic [POS_W-1:0] POS_ID       = 4'd1;
    localparam logic [POS_W-1:0] POS_MAX      = 4'd15;
    // last position index of the shortest accepted packet per layout
    localparam logic [POS_W-1:0] FULL_MIN_POS    = 4'd12;
    localparam logic [POS_W-1:0] MINIMAL_MIN_POS = 4'd8;

    localparam logic [SLOT_W-1:0] SLOT_BTN0 = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_BTN1 = 3'd5;
    localparam logic [SLOT_W-1:0] SLOT_BTN2 = 3'd6;

    localparam logic [3:0] HAT_MAX     = 4'd7;
    localparam logic [3:0] HAT_NEUTRAL = 4'd8;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] idx;
    } t_slot;

    typedef struct packed {
        logic                   emit;
        logic [NUM_CAP-1:0][BYTE_W-1:0] bytes;
    } t_raw_rep;

    function automatic t_slot slot_for(input logic [BYTE_W-1:0] id,
                                       input logic [POS_W-1:0] pos);
        t_slot s;
        s.hit = 1'b0;
        s.idx = '0;
        if (id == ID_FULL) begin
            if (pos >= 4'd3 && pos <= 4'd6) begin
                s.hit = 1'b1;
                s.idx = SLOT_W'(pos - 4'd3);
            end else if (pos >= 4'd10 && pos <= 4'd12) begin
                s.hit = 1'b1;
                s.idx = SLOT_W'(pos - 4'd6);
            end
        end else if (id == ID_MINIMAL) begin
            if (pos >= 4'd2 && pos <= 4'd8) begin
                s.hit = 1'b1;
                s.idx = SLOT_W'(pos - 4'd2);
            end
        end
        return s;
    endfunction

endpackage

// ===== rtl/gpr_capture.sv =====
// packet position tracking, layout check and capture of stick and button bytes
module gpr_capture import gpr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    output t_raw_rep          o_rep
);

    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_prefix_ok, n_prefix_ok;
    logic [BYTE_W-1:0] r_layout_id, n_layout_id;
    logic [NUM_CAP-1:0][BYTE_W-1:0] r_bytes, n_bytes;
    t_slot             slot;
    logic              len_ok;

    assign slot = slot_for(r_layout_id, r_pos);

    always_comb begin
        n_pos       = r_pos;
        n_prefix_ok = r_prefix_ok;
        n_layout_id = r_layout_id;
        n_bytes     = r_bytes;
        if (i_step) begin
            if (r_pos == POS_PREFIX) begin
                n_prefix_ok = (i_byte == PREFIX_BYTE);
            end else if (r_pos == POS_ID) begin
                n_layout_id = i_byte;
            end else if (slot.hit) begin
                n_bytes[slot.idx] = i_byte;
            end
            if (i_last) begin
                n_pos       = POS_PREFIX;
                n_prefix_ok = 1'b0;
                n_layout_id = '0;
            end else if (r_pos != POS_MAX) begin
                n_pos = r_pos + 4'd1;
            end
        end
    end

    assign len_ok = ((r_layout_id == ID_FULL) && (r_pos >= FULL_MIN_POS)) ||
                    ((r_layout_id == ID_MINIMAL) && (r_pos >= MINIMAL_MIN_POS));

    // bytes are forwarded so a capture on the final word is seen at once
    assign o_rep.emit  = i_step && i_last && r_prefix_ok && len_ok;
    assign o_rep.bytes = n_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_PREFIX;
            r_prefix_ok <= 1'b0;
            r_layout_id <= '0;
        end else begin
            r_pos       <= n_pos;
            r_prefix_ok <= n_prefix_ok;
            r_layout_id <= n_layout_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

endmodule

// ===== rtl/gpr_format.sv =====
// result register with hat and button field decode
module gpr_format import gpr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  t_raw_rep          i_rep,
    output logic              o_valid,
    output logic [7:0]        o_left_stick_x,
    output logic [7:0]        o_left_stick_y,
    output logic [7:0]        o_right_stick_x,
    output logic [7:0]        o_right_stick_y,
    output logic [3:0]        o_hat_direction,
    output logic [3:0]        o_face_buttons,
    output logic [7:0]        o_shoulder_buttons,
    output logic [1:0]        o_system_buttons
);

    logic       r_valid;
    logic [7:0] r_lx, r_ly, r_rx, r_ry, r_shoulder;
    logic [3:0] r_hat, r_face;
    logic [1:0] r_sys;
    logic [3:0] hat_raw;

    assign hat_raw = i_rep.bytes[SLOT_BTN0][3:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_rep.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_rep.emit) begin
            r_lx       <= i_rep.bytes[0];
            r_ly       <= i_rep.bytes[1];
            r_rx       <= i_rep.bytes[2];
            r_ry       <= i_rep.bytes[3];
            r_hat      <= (hat_raw > HAT_MAX) ? HAT_NEUTRAL : hat_raw;
            r_face     <= i_rep.bytes[SLOT_BTN0][7:4];
            r_shoulder <= i_rep.bytes[SLOT_BTN1];
            r_sys      <= i_rep.bytes[SLOT_BTN2][1:0];
        end
    end

    assign o_valid            = r_valid;
    assign o_left_stick_x     = r_lx;
    assign o_left_stick_y     = r_ly;
    assign o_right_stick_x    = r_rx;
    assign o_right_stick_y    = r_ry;
    assign o_hat_direction    = r_hat;
    assign o_face_buttons     = r_face;
    assign o_shoulder_buttons = r_shoulder;
    assign o_system_buttons   = r_sys;

endmodule

// ===== rtl/gamepad_report_decoder.sv =====
// a final word passes through the input register, then its report is held in the result register
// throughput: one packet word per cycle while o_in_stall is low; the result register parts the two sides
// a waiting report stalls the input only once the input register is also full
// reset: synchronous active-low i_rst_n clears position, prefix, layout and valids
// captured bytes are not reset; a report only uses bytes written in its own packet
module gamepad_report_decoder import gpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_packet_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_left_stick_x,
    output logic [7:0]  o_left_stick_y,
    output logic [7:0]  o_right_stick_x,
    output logic [7:0]  o_right_stick_y,
    output logic [3:0]  o_hat_direction,
    output logic [3:0]  o_face_buttons,
    output logic [7:0]  o_shoulder_buttons,
    output logic [1:0]  o_system_buttons
);

    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_last;
    logic              advance;
    logic              accept;
    t_raw_rep          rep;

    assign advance    = !o_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance || !r_s1_valid) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_byte <= i_packet_byte;
            r_s1_last <= i_last_byte;
        end
    end

    gpr_capture u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (r_s1_valid && advance),
        .i_byte  (r_s1_byte),
        .i_last  (r_s1_last),
        .o_rep   (rep)
    );

    gpr_format u_format (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_advance          (advance),
        .i_rep              (rep),
        .o_valid            (o_out_valid),
        .o_left_stick_x     (o_left_stick_x),
        .o_left_stick_y     (o_left_stick_y),
        .o_right_stick_x    (o_right_stick_x),
        .o_right_stick_y    (o_right_stick_y),
        .o_hat_direction    (o_hat_direction),
        .o_face_buttons     (o_face_buttons),
        .o_shoulder_buttons (o_shoulder_buttons),
        .o_system_buttons   (o_system_buttons)
    );

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with empty input register");

    a_report_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_s1_valid && r_s1_last && advance))
        else $error("report raised without a final word");

    a_hat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hat_direction <= HAT_NEUTRAL))
        else $error("hat direction out of range");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("valid or stall left set after reset");

endmodule
